>>> rtl/lpjl_pkg.sv
// Package: pool size, action codes and the types shared by the pending job list.
`default_nettype none

package lpjl_pkg;

  localparam int NUM_JOBS = 16;
  localparam int JOB_W    = 4;
  localparam int ACT_W    = 3;

  localparam logic [ACT_W-1:0] ACT_SET     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_UNSET   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_EXECUTE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_PULL = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [JOB_W-1:0] job;
  } cell_cmd_t;

  typedef struct packed {
    logic             valid;
    logic [JOB_W-1:0] job;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/lpjl_if.sv
// Interfaces: request and result channels of the pending job list.
`default_nettype none

interface lpjl_in_if;
  import lpjl_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [JOB_W-1:0] job_id;

  modport source (output valid, action, job_id, input ready);
  modport sink   (input valid, action, job_id, output ready);
endinterface

interface lpjl_out_if;
  import lpjl_pkg::*;
  logic             valid;
  logic             ready;
  logic [JOB_W-1:0] top_job;
  logic             top_valid;
  logic             job_pending;
  logic             any_pending;
  logic             empty_error;

  modport source (output valid, top_job, top_valid, job_pending, any_pending, empty_error,
                  input ready);
  modport sink   (input valid, top_job, top_valid, job_pending, any_pending, empty_error,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/lpjl_cell.sv
// One stack slot: holds an entry, pushes from above or pulls from below.
`default_nettype none

module lpjl_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lpjl_pkg::cell_cmd_t cmd,
  input  lpjl_pkg::entry_t   upper,
  input  lpjl_pkg::entry_t   lower,
  input  logic               hit_in,
  output logic               hit_out,
  output logic               own_hit,
  output lpjl_pkg::entry_t   entry
);
  import lpjl_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  assign own_hit = entry_r.valid && (entry_r.job == cmd.job);
  assign hit_out = hit_in || own_hit;
  assign entry   = entry_r;

  // push: slots above the removed copy move down one; pull: slots from the hit move up
  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.op)
      CELL_HOLD: entry_nxt = entry_r;
      CELL_PUSH: if (!hit_in) begin
        entry_nxt = upper;
      end
      CELL_PULL: if (hit_in || own_hit) begin
        entry_nxt = lower;
      end
      default:   entry_nxt = entry_r;
    endcase
  end

  // only the occupancy bit is reset; the job number is don't-care while empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.job <= entry_nxt.job;
  end

endmodule

`default_nettype wire

>>> rtl/lifo_pending_job_list_top.sv
// Top level: LIFO list of pending jobs built as a row of stack cells.
//
// Usage:
//   in_ch  (sink)  : one request per transfer, action plus job_id.
//                    set, unset, execute (pop top), peek, query.
//   out_ch (source): exactly one result per request, in request order.
//   The row of cells holds the stack, top in cell 0. A request is applied to
//   every cell in the cycle it is accepted: compares against the job number
//   ripple down the row, and each cell either keeps its entry, takes the one
//   above (push) or the one below (removal / pop).
// Output: the result is registered and appears in the cycle after the transfer.
// Throughput: one request per cycle while out_ch takes each result; the compare
//   and shift over all cells are combinational.
// Stall: the output register holds a waiting result; a new request is taken
//   in the cycle the result is taken (in_ch.ready = !out valid || out ready).
// Reset: synchronous, active low; empties the stack and drops any result.
//   Pending marks follow from presence in the stack, so they clear too.
`default_nettype none

module lifo_pending_job_list_top (
  input  logic clk,
  input  logic rst_n,
  lpjl_in_if.sink    in_ch,
  lpjl_out_if.source out_ch
);
  import lpjl_pkg::*;

  logic                in_fire;
  logic                in_pool;
  cell_cmd_t           cmd;
  logic                pop_start;
  entry_t              ent     [NUM_JOBS];
  logic [NUM_JOBS:0]   hit;
  logic [NUM_JOBS-1:0] match;
  logic [NUM_JOBS-1:0] valid_vec;
  logic                pending_before;
  logic                empty;
  logic                is_set;
  logic                is_unset;
  logic                is_exec;
  logic                is_peek;

  // result register
  logic             out_valid_r;
  logic [JOB_W-1:0] top_job_r,     top_job_nxt;
  logic             top_valid_r,   top_valid_nxt;
  logic             job_pending_r, job_pending_nxt;
  logic             any_pending_r, any_pending_nxt;
  logic             empty_error_r, empty_error_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_pool     = int'(in_ch.job_id) < NUM_JOBS;

  assign is_set   = in_ch.action == ACT_SET;
  assign is_unset = in_ch.action == ACT_UNSET;
  assign is_exec  = in_ch.action == ACT_EXECUTE;
  assign is_peek  = in_ch.action == ACT_PEEK;

  assign empty          = !ent[0].valid;
  assign pending_before = |match;

  // pop is a removal whose hit starts at the top cell
  assign pop_start = in_fire && is_exec;
  assign hit[0]    = pop_start;

  always_comb begin
    cmd.job = in_ch.job_id;
    cmd.op  = CELL_HOLD;
    if (in_fire) begin
      priority if (is_set && in_pool) begin
        cmd.op = CELL_PUSH;
      end else if (is_unset && in_pool && pending_before) begin
        cmd.op = CELL_PULL;
      end else if (is_exec && !empty) begin
        cmd.op = CELL_PULL;
      end else begin
        cmd.op = CELL_HOLD;
      end
    end
  end

  // row of cells, top of stack in cell 0
  for (genvar i = 0; i < NUM_JOBS; i++) begin : g_cell
    entry_t upper;
    entry_t lower;
    if (i == 0) begin : g_top
      assign upper = '{valid: 1'b1, job: in_ch.job_id};
    end else begin : g_mid_up
      assign upper = ent[i-1];
    end
    if (i == NUM_JOBS - 1) begin : g_bottom
      assign lower = '{valid: 1'b0, job: '0};
    end else begin : g_mid_low
      assign lower = ent[i+1];
    end

    lpjl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .upper   (upper),
      .lower   (lower),
      .hit_in  (hit[i]),
      .hit_out (hit[i+1]),
      .own_hit (match[i]),
      .entry   (ent[i])
    );

    assign valid_vec[i] = ent[i].valid;
  end

  // result for the request, from the state before it is applied
  always_comb begin
    top_job_nxt     = '0;
    top_valid_nxt   = 1'b0;
    empty_error_nxt = is_exec && empty;
    if ((is_exec || is_peek) && !empty) begin
      top_job_nxt   = ent[0].job;
      top_valid_nxt = 1'b1;
    end

    priority if (!in_pool) begin
      job_pending_nxt = 1'b0;
    end else if (is_set) begin
      job_pending_nxt = 1'b1;
    end else if (is_unset) begin
      job_pending_nxt = 1'b0;
    end else if (is_exec) begin
      // still pending only if a copy sits below the popped top
      job_pending_nxt = |match[NUM_JOBS-1:1];
    end else begin
      job_pending_nxt = pending_before;
    end

    priority if (is_set && in_pool) begin
      any_pending_nxt = 1'b1;
    end else if (is_unset && in_pool && pending_before) begin
      any_pending_nxt = ent[1].valid;
    end else if (is_exec) begin
      any_pending_nxt = ent[1].valid;
    end else begin
      any_pending_nxt = ent[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      top_job_r     <= top_job_nxt;
      top_valid_r   <= top_valid_nxt;
      job_pending_r <= job_pending_nxt;
      any_pending_r <= any_pending_nxt;
      empty_error_r <= empty_error_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_job     = top_job_r;
  assign out_ch.top_valid   = top_valid_r;
  assign out_ch.job_pending = job_pending_r;
  assign out_ch.any_pending = any_pending_r;
  assign out_ch.empty_error = empty_error_r;

  // occupied cells always form an unbroken run from the top
  a_stack_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + NUM_JOBS'(1)) & valid_vec) == '0)
    else $error("stack cells not contiguous");

  // a set job lands on top of the stack
  a_set_on_top: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_set && in_pool) |=>
      (ent[0].valid && ent[0].job == $past(in_ch.job_id)))
    else $error("set job not on top");

  // a pop on an empty list never reports a job
  a_err_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.empty_error && out_ch.top_valid))
    else $error("empty error with valid top");

endmodule

`default_nettype wire

>>> dv/lifo_pending_job_list_top_tb.sv
// Testbench: randomised request/result checking of the LIFO pending job list top level.
`default_nettype none

module lifo_pending_job_list_top_tb;
  import lpjl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Action codes 5..7 are spare: the block must treat them as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

  localparam int N_RANDOM   = 1200;
  localparam int IDLE_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int TAIL_WAIT  = 4;     // result is registered

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [JOB_W-1:0] job_id;
    logic             drain_first;  // sender holds off until all results are back
  } job_req_t;

  typedef struct packed {
    logic [JOB_W-1:0] top_job;
    logic             top_valid;
    logic             job_pending;
    logic             any_pending;
    logic             empty_error;
  } job_result_t;

  logic clk;
  logic rst_n;

  lpjl_in_if  in_ch ();
  lpjl_out_if out_ch ();

  lifo_pending_job_list_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the job list: stack bottom at entry 0, top at depth-1
  // ---------------------------------------------------------------------------
  logic [JOB_W-1:0] job_stack [NUM_JOBS];
  logic [NUM_JOBS-1:0] marks = '0;
  int unsigned depth = 0;

  job_req_t    req_queue[$];     // requests still to be offered
  job_result_t result_queue[$];  // predicted results, oldest first

  job_req_t cur_req;
  bit       in_busy = 1'b0;      // cur_req is on the bus, waiting for its transfer
  int       in_gap = 0;
  int       out_stall = 0;
  int       n_sent = 0;          // driver-owned
  int       n_done = 0;          // monitor-owned, updated by NBA so the driver sees it cleanly
  int       errors = 0;
  int       idle_cycles = 0;

  int act_count [8];
  int n_empty_err = 0;
  int max_depth = 0;

  // Drop a job from the list, closing the gap so order is kept
  function automatic void remove_from_stack(logic [JOB_W-1:0] job);
    int unsigned w;
    w = 0;
    for (int unsigned i = 0; i < depth; i++) begin
      if (job_stack[i] != job) begin
        job_stack[w] = job_stack[i];
        w++;
      end
    end
    depth = w;
  endfunction

  // Apply one request to the shadow list and return the result it must give.
  // With a 16-job pool every 4-bit job number is in range.
  function automatic job_result_t apply_job_request(job_req_t req);
    job_result_t res;
    res = '0;
    case (req.action)
      ACT_SET: begin
        // re-setting a pending job moves it to the top
        if (marks[req.job_id]) remove_from_stack(req.job_id);
        if (depth < NUM_JOBS) begin
          job_stack[depth] = req.job_id;
          depth++;
        end
        marks[req.job_id] = 1'b1;
      end
      ACT_UNSET: begin
        if (marks[req.job_id]) begin
          remove_from_stack(req.job_id);
          marks[req.job_id] = 1'b0;
        end
      end
      ACT_EXECUTE: begin
        if (depth == 0) begin
          res.empty_error = 1'b1;
        end else begin
          res.top_job   = job_stack[depth-1];
          res.top_valid = 1'b1;
          depth--;
          marks[res.top_job] = 1'b0;
        end
      end
      ACT_PEEK: begin
        if (depth != 0) begin
          res.top_job   = job_stack[depth-1];
          res.top_valid = 1'b1;
        end
      end
      default: ;  // query and spare codes change nothing
    endcase
    res.job_pending = marks[req.job_id];
    res.any_pending = (depth != 0);
    return res;
  endfunction

  task automatic push_req(logic [ACT_W-1:0] act, logic [JOB_W-1:0] job, bit drain);
    job_req_t r;
    r.action      = act;
    r.job_id      = job;
    r.drain_first = drain;
    req_queue.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Known values on every block input from time zero
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_SET;
    in_ch.job_id  = '0;
    out_ch.ready  = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests, idling for a random gap after each transfer.
  // Every third stretch of 64 requests runs back to back.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.action <= ACT_SET;
      in_ch.job_id <= '0;
      in_busy = 1'b0;
      in_gap  = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        result_queue.push_back(apply_job_request(cur_req));
        act_count[cur_req.action]++;
        if (depth > max_depth) max_depth = depth;
        n_sent++;
        in_busy = 1'b0;
        in_gap  = (((n_sent / 64) % 3) != 0) ? $urandom_range(0, 7) : 0;
      end
      if (!in_busy) begin
        if (in_gap != 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (req_queue.size() != 0 && req_queue[0].drain_first && n_done != n_sent) begin
          // hold off until every outstanding result has been taken
          in_ch.valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          cur_req = req_queue.pop_front();
          in_ch.action <= cur_req.action;
          in_ch.job_id <= cur_req.job_id;
          in_ch.valid  <= 1'b1;
          in_busy = 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results, stalling for a random gap after each transfer, and
  // compares them field by field with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    job_result_t exp_res;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_queue.size() == 0) begin
          $error("unexpected result: top_job %0d top_valid %0b", out_ch.top_job,
                 out_ch.top_valid);
          errors++;
        end else begin
          exp_res = result_queue.pop_front();
          if (out_ch.top_job !== exp_res.top_job) begin
            $error("top_job: expected %0d, got %0d", exp_res.top_job, out_ch.top_job);
            errors++;
          end
          if (out_ch.top_valid !== exp_res.top_valid) begin
            $error("top_valid: expected %0b, got %0b", exp_res.top_valid, out_ch.top_valid);
            errors++;
          end
          if (out_ch.job_pending !== exp_res.job_pending) begin
            $error("job_pending: expected %0b, got %0b", exp_res.job_pending,
                   out_ch.job_pending);
            errors++;
          end
          if (out_ch.any_pending !== exp_res.any_pending) begin
            $error("any_pending: expected %0b, got %0b", exp_res.any_pending,
                   out_ch.any_pending);
            errors++;
          end
          if (out_ch.empty_error !== exp_res.empty_error) begin
            $error("empty_error: expected %0b, got %0b", exp_res.empty_error,
                   out_ch.empty_error);
            errors++;
          end
          if (exp_res.empty_error) n_empty_err++;
        end
        n_done <= n_done + 1;
        out_stall = (((n_done / 64) % 3) != 1) ? $urandom_range(0, 7) : 0;
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a transfer on either channel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("lifo_pending_job_list_top test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int               pick;
    logic [ACT_W-1:0] act;
    logic [JOB_W-1:0] job;

    rst_n = 1'b0;

    // Directed opening: empty-list corners, extreme job numbers, re-set to
    // top, removal from the bottom, spare codes, pop down to empty
    push_req(ACT_EXECUTE, 4'd0,  1'b0);  // execute on an empty list
    push_req(ACT_PEEK,    4'd15, 1'b0);  // peek on an empty list
    push_req(ACT_QUERY,   4'd0,  1'b0);
    push_req(ACT_SPARE_A, 4'd15, 1'b0);
    push_req(ACT_UNSET,   4'd15, 1'b0);  // unset of a job not pending
    push_req(ACT_SET,     4'd0,  1'b0);
    push_req(ACT_SET,     4'd15, 1'b0);
    push_req(ACT_SET,     4'd7,  1'b0);
    push_req(ACT_SET,     4'd0,  1'b0);  // already pending: moves to top
    push_req(ACT_PEEK,    4'd3,  1'b0);
    push_req(ACT_QUERY,   4'd15, 1'b0);
    push_req(ACT_UNSET,   4'd15, 1'b0);  // removal below the top
    push_req(ACT_SPARE_B, 4'd7,  1'b0);
    push_req(ACT_SPARE_C, 4'd0,  1'b0);
    push_req(ACT_EXECUTE, 4'd9,  1'b0);
    push_req(ACT_EXECUTE, 4'd0,  1'b0);
    push_req(ACT_EXECUTE, 4'd0,  1'b0);  // pops past the bottom
    push_req(ACT_QUERY,   4'd7,  1'b0);

    // Random part in stretches of 40: mixed traffic, a fill stretch that
    // drives the list to full, and a drain stretch that pops it back down
    for (int k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 99);
      job  = JOB_W'($urandom_range(0, NUM_JOBS - 1));
      case ((k / 40) % 5)
        2: begin
          act = (pick < 85) ? ACT_SET : ((pick < 92) ? ACT_PEEK : ACT_QUERY);
          // mostly distinct jobs so the stack actually fills
          if ($urandom_range(0, 3) != 0) job = k[JOB_W-1:0];
        end
        4: act = (pick < 75) ? ACT_EXECUTE : ((pick < 85) ? ACT_UNSET : ACT_PEEK);
        default: begin
          if      (pick < 35) act = ACT_SET;
          else if (pick < 50) act = ACT_UNSET;
          else if (pick < 70) act = ACT_EXECUTE;
          else if (pick < 80) act = ACT_PEEK;
          else if (pick < 92) act = ACT_QUERY;
          else                act = ACT_W'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
        end
      endcase
      push_req(act, job, (k == N_RANDOM / 2));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the last request to go and its result to come back
    @(negedge clk);
    while (req_queue.size() != 0 || in_busy || n_done != n_sent) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);

    if (result_queue.size() != 0) begin
      $error("%0d predicted results never arrived", result_queue.size());
      errors++;
    end

    $display("%0d requests: set %0d, unset %0d, execute %0d, peek %0d, query %0d, spare %0d",
             n_sent, act_count[ACT_SET], act_count[ACT_UNSET], act_count[ACT_EXECUTE],
             act_count[ACT_PEEK], act_count[ACT_QUERY],
             act_count[ACT_SPARE_A] + act_count[ACT_SPARE_B] + act_count[ACT_SPARE_C]);
    $display("%0d executes on an empty list, deepest list %0d of %0d jobs, %0d errors",
             n_empty_err, max_depth, NUM_JOBS, errors);

    if (errors == 0) begin
      $display("lifo_pending_job_list_top test passed");
    end else begin
      $display("lifo_pending_job_list_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
